// File: sv/crti_pkg.sv
// ----------------------------------------------------------------------------
// crti_pkg
// Shared types and constants of the CSDA range trapezoid integrator: item
// layouts, configuration register map, widths and controller states.
// ----------------------------------------------------------------------------
package crti_pkg;

  localparam int SP_W       = 32;
  localparam int RECIP_W    = 41;
  localparam int EN_W       = 32;
  localparam int RATIO_W    = 31;
  localparam int MASS_W     = 9;
  localparam int ACC_W      = 64;
  localparam int RATIO_FRAC = 30;
  localparam int INC_SHIFT  = 17;
  localparam int SCALE_W    = EN_W + MASS_W;
  localparam int PROD_W     = SCALE_W + RECIP_W;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;

  localparam logic [MASS_W-1:0]  MASS_RST  = 9'd1;
  localparam logic [EN_W-1:0]    EMIN_RST  = 32'd66;
  localparam logic [RATIO_W-1:0] RATIO_RST = 31'h4000_0000;
  localparam logic [RECIP_W-1:0] RECIP_MAX = {1'b0, {(RECIP_W-1){1'b1}}};

  typedef enum logic [1:0] {
    REG_MASS  = 2'd0,
    REG_EMIN  = 2'd1,
    REG_RATIO = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [SP_W-1:0] stopping_power;
    logic            first_point;
  } in_item_t;

  typedef struct packed {
    logic [ACC_W-1:0] range_value;
    logic             saturated;
  } out_item_t;

  typedef struct packed {
    logic [MASS_W-1:0]  proj_mass_number;
    logic [EN_W-1:0]    grid_min_energy;
    logic [RATIO_W-1:0] grid_ratio;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENERGY,
    ST_SCALE,
    ST_PRODUCT,
    ST_ACCUM
  } state_t;

endpackage

// File: sv/csda_range_trapezoid_integrator_unit.sv
// ----------------------------------------------------------------------------
// csda_range_trapezoid_integrator_unit
// Running CSDA range from stopping-power samples on a geometric energy grid.
// ----------------------------------------------------------------------------
// Each item carries one stopping-power sample and gives one result: the range
// accumulated in the column so far, Q32.32, with a sticky saturation flag.
// An item is worked through in full before the next one can be accepted:
// the bit-serial reciprocal divider needs 41 steps, while the 31-step grid
// energy multiply, followed by the 9-step mass scaling, runs beside it; then
// a 41-step shift-add multiply forms the trapezoid area for the accumulator.
// The result sits in an output register, so the next item is taken while it
// waits; only a result not yet taken when the following one is done stalls.
// ----------------------------------------------------------------------------
module csda_range_trapezoid_integrator_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  crti_pkg::in_item_t          in_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output crti_pkg::out_item_t         out_item,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [crti_pkg::ADDR_W-1:0] paddr,
  input  logic [crti_pkg::DATA_W-1:0] pwdata,
  output logic [crti_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import crti_pkg::*;

  cfg_t   cfg;
  state_t state_r, state_nxt;

  logic                 in_accept;
  logic                 em_start, sc_start, fm_start, commit, slot_free;
  logic                 dv_busy, em_busy, sc_busy, fm_busy;
  logic [RECIP_W-1:0]   dv_recip;
  logic [EN_W+RATIO_W-1:0] em_prod;
  logic [SCALE_W-1:0]   sc_prod;
  logic [PROD_W-1:0]    fm_prod;

  logic                 first_r;
  logic [RECIP_W-1:0]   prev_inv_r, prev_inv_nxt;
  logic [EN_W-1:0]      prev_e_r, prev_e_nxt;
  logic [EN_W-1:0]      e_cur_r;
  logic [ACC_W-1:0]     acc_r, acc_nxt;
  logic                 sat_r, sat_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_item_r;

  logic [EN_W:0]        e_scaled, e_diff;
  logic [EN_W-1:0]      e_next, delta;
  logic [RECIP_W-1:0]   recip_sum;
  logic [ACC_W:0]       inc_wide, acc_sum;

  crti_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  crti_divider u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (in_accept),
    .divisor (in_item.stopping_power),
    .busy    (dv_busy),
    .recip   (dv_recip)
  );

  crti_serial_mult #(.A_W(EN_W), .B_W(RATIO_W)) u_energy_mult (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (em_start),
    .mcand   (prev_e_r),
    .mplier  (cfg.grid_ratio),
    .busy    (em_busy),
    .product (em_prod)
  );

  crti_serial_mult #(.A_W(EN_W), .B_W(MASS_W)) u_scale_mult (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (sc_start),
    .mcand   (delta),
    .mplier  (cfg.proj_mass_number),
    .busy    (sc_busy),
    .product (sc_prod)
  );

  crti_serial_mult #(.A_W(SCALE_W), .B_W(RECIP_W)) u_area_mult (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (fm_start),
    .mcand   (sc_prod),
    .mplier  (recip_sum),
    .busy    (fm_busy),
    .product (fm_prod)
  );

  // grid energy step and interval width
  assign e_scaled  = em_prod[EN_W+RATIO_W-1:RATIO_FRAC];
  assign e_next    = e_scaled[EN_W] ? '1 : e_scaled[EN_W-1:0];
  assign e_diff    = {1'b0, e_next} - {1'b0, prev_e_r};
  assign delta     = e_diff[EN_W] ? '0 : e_diff[EN_W-1:0];
  assign recip_sum = prev_inv_r + dv_recip;

  // increment and saturating accumulate
  assign inc_wide  = fm_prod[PROD_W-1:INC_SHIFT];
  assign acc_sum   = {1'b0, acc_r} + {1'b0, inc_wide[ACC_W-1:0]};

  assign slot_free = ~out_valid_r | out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (in_valid) state_nxt = ST_ENERGY;
      ST_ENERGY:  if (!em_busy) state_nxt = ST_SCALE;
      ST_SCALE:   if (!sc_busy && !dv_busy) state_nxt = ST_PRODUCT;
      ST_PRODUCT: if (!fm_busy) state_nxt = ST_ACCUM;
      ST_ACCUM:   if (slot_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    em_start = 1'b0;
    sc_start = 1'b0;
    fm_start = 1'b0;
    commit   = 1'b0;
    unique case (state_r)
      ST_IDLE:    in_ready = 1'b1;
      ST_ENERGY:  sc_start = ~em_busy;
      ST_SCALE:   fm_start = ~sc_busy & ~dv_busy;
      ST_PRODUCT: commit   = 1'b0;
      ST_ACCUM:   commit   = slot_free;
      default:    in_ready = 1'b0;
    endcase
    in_accept = in_ready & in_valid;
    em_start  = in_accept;
  end

  always_comb begin
    prev_inv_nxt  = prev_inv_r;
    prev_e_nxt    = prev_e_r;
    acc_nxt       = acc_r;
    sat_nxt       = sat_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    if (commit) begin
      prev_inv_nxt  = dv_recip;
      out_valid_nxt = 1'b1;
      if (first_r) begin
        prev_e_nxt = cfg.grid_min_energy;
        acc_nxt    = '0;
        sat_nxt    = 1'b0;
      end else begin
        prev_e_nxt = e_cur_r;
        if (inc_wide[ACC_W] || acc_sum[ACC_W]) begin
          acc_nxt = '1;
          sat_nxt = 1'b1;
        end else begin
          acc_nxt = acc_sum[ACC_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      prev_inv_r  <= '0;
      prev_e_r    <= '0;
      acc_r       <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prev_inv_r  <= prev_inv_nxt;
      prev_e_r    <= prev_e_nxt;
      acc_r       <= acc_nxt;
      sat_r       <= sat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      first_r <= in_item.first_point;
    end
    if (sc_start) begin
      e_cur_r <= e_next;
    end
    if (commit) begin
      out_item_r.range_value <= acc_nxt;
      out_item_r.saturated   <= sat_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// File: sv/crti_cfg_regs.sv
// ----------------------------------------------------------------------------
// crti_cfg_regs
// APB-style configuration registers: mass number, grid minimum energy and
// grid energy ratio, with read back.
// ----------------------------------------------------------------------------
module crti_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [crti_pkg::ADDR_W-1:0] paddr,
  input  logic [crti_pkg::DATA_W-1:0] pwdata,
  output logic [crti_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output crti_pkg::cfg_t              cfg
);
  import crti_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_MASS:  cfg_nxt.proj_mass_number = pwdata[MASS_W-1:0];
        REG_EMIN:  cfg_nxt.grid_min_energy  = pwdata[EN_W-1:0];
        REG_RATIO: cfg_nxt.grid_ratio       = pwdata[RATIO_W-1:0];
        default:   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MASS:  prdata = DATA_W'(cfg_r.proj_mass_number);
      REG_EMIN:  prdata = DATA_W'(cfg_r.grid_min_energy);
      REG_RATIO: prdata = DATA_W'(cfg_r.grid_ratio);
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{proj_mass_number: MASS_RST, grid_min_energy: EMIN_RST,
                 grid_ratio: RATIO_RST};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: sv/crti_divider.sv
// ----------------------------------------------------------------------------
// crti_divider
// Bit-serial restoring divider for the reciprocal floor(2^40 / sp), one
// quotient bit per cycle, saturated to 40 bits and zero for a zero sample.
// ----------------------------------------------------------------------------
module crti_divider (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [crti_pkg::SP_W-1:0]    divisor,
  output logic                         busy,
  output logic [crti_pkg::RECIP_W-1:0] recip
);
  import crti_pkg::*;

  localparam int CNT_W = $clog2(RECIP_W + 1);

  logic [SP_W-1:0]    div_r, rem_r, rem_nxt;
  logic [RECIP_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               zero_r;
  logic               lead_bit;
  logic               q_bit;
  logic [SP_W:0]      trial, diff;

  // dividend is a single one followed by zeros, fed msb first
  assign lead_bit = (cnt_r == '0);
  assign trial    = {rem_r, lead_bit};
  assign diff     = trial - {1'b0, div_r};
  assign q_bit    = ~diff[SP_W];

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start && !busy_r) begin
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = q_bit ? diff[SP_W-1:0] : trial[SP_W-1:0];
      quo_nxt = {quo_r[RECIP_W-2:0], q_bit};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(RECIP_W - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start && !busy_r) begin
      div_r  <= divisor;
      zero_r <= (divisor == '0);
    end
  end

  assign busy  = busy_r;
  assign recip = zero_r ? '0 : (quo_r[RECIP_W-1] ? RECIP_MAX : quo_r);

endmodule

// File: sv/crti_serial_mult.sv
// ----------------------------------------------------------------------------
// crti_serial_mult
// Shift-add multiplier, one multiplier bit per cycle lsb first; the low
// product bits shift into the multiplier register as it empties.
// ----------------------------------------------------------------------------
module crti_serial_mult #(
  parameter int A_W = 32,
  parameter int B_W = 31
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [A_W-1:0]     mcand,
  input  logic [B_W-1:0]     mplier,
  output logic               busy,
  output logic [A_W+B_W-1:0] product
);
  localparam int CNT_W = $clog2(B_W + 1);

  logic [A_W-1:0]   mcand_r;
  logic [A_W-1:0]   hi_r, hi_nxt;
  logic [B_W-1:0]   lo_r, lo_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [A_W:0]     sum;

  assign busy = (cnt_r != '0);
  assign sum  = {1'b0, hi_r} + (lo_r[0] ? {1'b0, mcand_r} : '0);

  always_comb begin
    hi_nxt  = hi_r;
    lo_nxt  = lo_r;
    cnt_nxt = cnt_r;
    if (start && !busy) begin
      hi_nxt  = '0;
      lo_nxt  = mplier;
      cnt_nxt = CNT_W'(B_W);
    end else if (busy) begin
      hi_nxt  = sum[A_W:1];
      lo_nxt  = {sum[0], lo_r[B_W-1:1]};
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
    if (start && !busy) begin
      mcand_r <= mcand;
    end
  end

  assign product = {hi_r, lo_r};

endmodule

// File: sv/crti_checker.sv
// ----------------------------------------------------------------------------
// crti_checker
// Port-level checks of the range integrator, bound to the top level.
// ----------------------------------------------------------------------------
module crti_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input crti_pkg::out_item_t out_item
);
  import crti_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result item changed or dropped while stalled");

  a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.saturated |-> out_item.range_value == '1)
    else $error("saturated result without full-scale range");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind csda_range_trapezoid_integrator_unit crti_checker u_crti_checker (.*);

// File: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the CSDA range trapezoid integrator. Stopping-power
// items go in over valid/ready, grid settings over the APB-style port, and
// each result is checked field by field against an in-bench range integrator
// that tracks reciprocal, grid energy and the saturating Q32.32 range.
// ----------------------------------------------------------------------------
module tb;
  import crti_pkg::*;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  in_item_t          in_item   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_item_t         out_item;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [ADDR_W-1:0] paddr     = '0;
  logic [DATA_W-1:0] pwdata    = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  cfg_t               grid_cfg     = {MASS_RST, EMIN_RST, RATIO_RST};
  logic [RECIP_W-1:0] last_recip   = '0;
  logic [EN_W-1:0]    last_energy  = '0;
  logic [ACC_W-1:0]   column_range = '0;
  logic               column_sat   = 1'b0;

  out_item_t range_expected[$];
  int        errors          = 0;
  int        items_sent      = 0;
  int        results_checked = 0;
  int        columns_started = 0;
  int        phases_run      = 0;
  bit        calm            = 1'b0;
  int        stall_left      = 0;

  always #4 clk = ~clk;

  csda_range_trapezoid_integrator_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // advances the column by one sample and returns the expected range
  function automatic out_item_t integrate_sample(in_item_t it);
    logic [63:0]        quot;
    logic [RECIP_W-1:0] recip;
    logic [63:0]        scaled_e;
    logic [EN_W-1:0]    e_next;
    logic [EN_W-1:0]    span;
    logic [RECIP_W:0]   recip_sum;
    logic [50:0]        area;
    logic [127:0]       full;
    logic [ACC_W:0]     total;
    out_item_t          res;
    quot = (it.stopping_power == '0) ? 64'd0 : (64'd1 << 40) / {32'd0, it.stopping_power};
    recip = (quot > {23'd0, RECIP_MAX}) ? RECIP_MAX : quot[RECIP_W-1:0];
    if (it.first_point) begin
      last_energy  = grid_cfg.grid_min_energy;
      column_range = '0;
      column_sat   = 1'b0;
    end else begin
      scaled_e = ({32'd0, last_energy} * {33'd0, grid_cfg.grid_ratio}) >> RATIO_FRAC;
      e_next = (scaled_e > 64'hFFFF_FFFF) ? '1 : scaled_e[EN_W-1:0];
      span = (e_next > last_energy) ? e_next - last_energy : '0;
      recip_sum = {1'b0, last_recip} + {1'b0, recip};
      area = 51'(recip_sum) * 51'(grid_cfg.proj_mass_number);
      full = (128'(area) * 128'(span)) >> INC_SHIFT;
      total = {1'b0, column_range} + {1'b0, full[63:0]};
      if (full[127:64] != '0 || total[ACC_W]) begin
        column_range = '1;
        column_sat   = 1'b1;
      end else begin
        column_range = total[ACC_W-1:0];
      end
      last_energy = e_next;
    end
    last_recip = recip;
    res.range_value = column_range;
    res.saturated   = column_sat;
    return res;
  endfunction

  task automatic report_error(string msg);
    errors++;
    if (errors <= 100) begin
      $display("%0t ERROR %s", $time, msg);
    end
  endtask

  task automatic send_sample(logic [SP_W-1:0] sp, logic first);
    int gap;
    if (!calm && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= '{stopping_power: sp, first_point: first};
    do @(posedge clk); while (!in_ready);
    range_expected.push_back(integrate_sample(in_item));
    items_sent++;
    if (first) begin
      columns_started++;
    end
  endtask

  task automatic wait_idle();
    @(negedge clk) in_valid <= 1'b0;
    while (range_expected.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_MASS:  grid_cfg.proj_mass_number = val[MASS_W-1:0];
      REG_EMIN:  grid_cfg.grid_min_energy  = val[EN_W-1:0];
      REG_RATIO: grid_cfg.grid_ratio       = val[RATIO_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_grid(logic [MASS_W-1:0] mass, logic [EN_W-1:0] emin,
                          logic [RATIO_W-1:0] ratio);
    wait_idle();
    write_reg(REG_MASS, DATA_W'(mass));
    write_reg(REG_EMIN, DATA_W'(emin));
    write_reg(REG_RATIO, DATA_W'(ratio));
  endtask

  // reset grid: energy starts at zero, so nothing accumulates
  task automatic test_no_first_point();
    send_sample(32'd100, 1'b0);
    send_sample(32'd0, 1'b0);
    send_sample(32'd1, 1'b0);
  endtask

  task automatic test_field_extremes();
    set_grid(9'd511, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
    send_sample(32'hFFFF_FFFF, 1'b1);
    send_sample(32'd0, 1'b0);
    send_sample(32'd1, 1'b0);
    set_grid(9'd511, 32'd1, 31'h7FFF_FFFF);
    send_sample(32'd1, 1'b1);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
  endtask

  task automatic test_falling_energy();
    set_grid(9'd4, 32'h0100_0000, 31'h2000_0000);
    send_sample(32'd256, 1'b1);
    send_sample(32'd512, 1'b0);
    send_sample(32'd1, 1'b0);
    set_grid(9'd4, 32'h0100_0000, 31'd0);
    send_sample(32'd3, 1'b0);
  endtask

  task automatic test_zero_mass();
    set_grid(9'd0, 32'h0010_0000, 31'h4800_0000);
    send_sample(32'd1, 1'b1);
    send_sample(32'd1, 1'b0);
    send_sample(32'd77, 1'b0);
  endtask

  // huge increments saturate the range, a first point clears it
  task automatic test_saturation();
    set_grid(9'd511, 32'h4000_0000, 31'h7FFF_FFFF);
    send_sample(32'd1, 1'b1);
    send_sample(32'd1, 1'b0);
    send_sample(32'd1, 1'b0);
    send_sample(32'd1, 1'b0);
    send_sample(32'd3, 1'b1);
    send_sample(32'd2, 1'b0);
  endtask

  task automatic test_random_columns();
    int                 remaining;
    int                 len;
    bit                 noise;
    logic [SP_W-1:0]    sp;
    logic [MASS_W-1:0]  mass;
    logic [EN_W-1:0]    emin;
    logic [RATIO_W-1:0] ratio;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_grid(9'd300, 32'd1, 31'h4000_0000);
        5: set_grid(9'd1, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
        default: begin
          mass = ($urandom_range(0, 3) == 0) ? MASS_W'($urandom)
                                             : MASS_W'($urandom_range(1, 300));
          emin = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(1, 32'h0010_0000);
          ratio = ($urandom_range(0, 3) == 0) ? RATIO_W'($urandom)
                  : RATIO_W'(32'h4000_0000 + $urandom_range(0, 32'h0800_0000));
          set_grid(mass, emin, ratio);
        end
      endcase
      calm = (p == 5);
      remaining = 100;
      while (remaining > 0) begin
        len = $urandom_range(1, 40);
        if (len > remaining) begin
          len = remaining;
        end
        noise = ($urandom_range(0, 9) == 0);
        for (int k = 0; k < len; k++) begin
          case ($urandom_range(0, 9))
            0:       sp = '0;
            1:       sp = 32'd1;
            2:       sp = $urandom_range(2, 255);
            3, 4:    sp = $urandom_range(256, 65535);
            5:       sp = {1'b1, 31'($urandom)};
            default: sp = $urandom;
          endcase
          send_sample(sp, noise ? 1'($urandom_range(0, 1)) : (k == 0));
        end
        remaining -= len;
      end
      phases_run++;
    end
  endtask

  // result side back-pressure in short bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 12) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (range_expected.size() == 0) begin
        report_error($sformatf("unexpected item, range %h", out_item.range_value));
      end else begin
        want = range_expected.pop_front();
        results_checked++;
        if (out_item.range_value !== want.range_value) begin
          report_error($sformatf("range_value %h, want %h",
                                 out_item.range_value, want.range_value));
        end
        if (out_item.saturated !== want.saturated) begin
          report_error($sformatf("saturated %b, want %b",
                                 out_item.saturated, want.saturated));
        end
      end
    end
  end

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    test_no_first_point();
    test_field_extremes();
    test_falling_energy();
    test_zero_mass();
    test_saturation();
    test_random_columns();
    wait_idle();
    repeat (100) @(posedge clk);
    $display("sent %0d items in %0d columns, checked %0d results",
             items_sent, columns_started, results_checked);
    $display("grid extremes, falling energy, zero mass, saturation, %0d random grid phases",
             phases_run);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("timeout");
    $display("DONE: errors detected");
    $finish;
  end

endmodule
